[hw/rtl/mmpb_pkg.sv]
// ----------------------------------------------------------------------------
// mmpb_pkg
// Shared codes and types for the host/MCU mailbox port bridge.
// ----------------------------------------------------------------------------
package mmpb_pkg;

	localparam int unsigned ACTION_W = 4;
	localparam int unsigned BYTE_W   = 8;

	// Request codes carried on the action field.
	localparam logic [ACTION_W-1:0] ACT_HOST_WR   = 4'd0;
	localparam logic [ACTION_W-1:0] ACT_HOST_RD   = 4'd1;
	localparam logic [ACTION_W-1:0] ACT_HOST_STAT = 4'd2;
	localparam logic [ACTION_W-1:0] ACT_PA_WR     = 4'd3;
	localparam logic [ACTION_W-1:0] ACT_PA_DDR    = 4'd4;
	localparam logic [ACTION_W-1:0] ACT_PA_RD     = 4'd5;
	localparam logic [ACTION_W-1:0] ACT_PB_WR     = 4'd6;
	localparam logic [ACTION_W-1:0] ACT_PB_DDR    = 4'd7;
	localparam logic [ACTION_W-1:0] ACT_PB_RD     = 4'd8;
	localparam logic [ACTION_W-1:0] ACT_PC_WR     = 4'd9;
	localparam logic [ACTION_W-1:0] ACT_PC_DDR    = 4'd10;
	localparam logic [ACTION_W-1:0] ACT_PC_RD     = 4'd11;

	// Bit positions of the port B handshake lines, port C pins and status flags.
	localparam int unsigned FLAG0_BIT = 0;
	localparam int unsigned LOAD_BIT  = 1;
	localparam int unsigned SEND_BIT  = 2;
	localparam int unsigned SCRLO_BIT = 3;
	localparam int unsigned SCRHI_BIT = 4;

	// Configuration register index.
	localparam logic REG_VARIANT = 1'b0;

	typedef struct packed {
		logic [BYTE_W-1:0] read_data;
		logic              mcu_irq;
		logic [BYTE_W-1:0] scroll_low;
		logic [BYTE_W-1:0] scroll_high;
	} result_t;

endpackage

[hw/rtl/mmpb_core.sv]
// ----------------------------------------------------------------------------
// mmpb_core
// Mailbox latches, port registers and the result of one request.
// ----------------------------------------------------------------------------
module mmpb_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           accept,
	input  logic [mmpb_pkg::ACTION_W-1:0]  action,
	input  logic [mmpb_pkg::BYTE_W-1:0]    data,
	input  logic                           variant,
	output mmpb_pkg::result_t              result
);

	logic [mmpb_pkg::BYTE_W-1:0] host_byte_q, mcu_byte_q;
	logic                        host_full_q, mcu_full_q, irq_q;
	logic [mmpb_pkg::BYTE_W-1:0] pa_in_q, pa_out_q, pa_dir_q;
	logic [mmpb_pkg::BYTE_W-1:0] pb_out_q, pb_dir_q;
	logic [mmpb_pkg::BYTE_W-1:0] pc_out_q, pc_dir_q;
	logic [mmpb_pkg::BYTE_W-1:0] scr_lo_q, scr_hi_q;

	logic [mmpb_pkg::BYTE_W-1:0] host_byte_d, mcu_byte_d;
	logic                        host_full_d, mcu_full_d, irq_d;
	logic [mmpb_pkg::BYTE_W-1:0] pa_in_d, pa_out_d, pa_dir_d;
	logic [mmpb_pkg::BYTE_W-1:0] pb_out_d, pb_dir_d;
	logic [mmpb_pkg::BYTE_W-1:0] pc_out_d, pc_dir_d;
	logic [mmpb_pkg::BYTE_W-1:0] scr_lo_d, scr_hi_d;
	logic [mmpb_pkg::BYTE_W-1:0] rd;
	logic [mmpb_pkg::BYTE_W-1:0] pb_fall, pb_rise, pc_pins;

	// Enabled edges on port B, old latch against the new byte.
	assign pb_fall = pb_dir_q & pb_out_q & ~data;
	assign pb_rise = pb_dir_q & ~pb_out_q & data;

	always_comb begin
		pc_pins = '0;
		if (variant) begin
			pc_pins[mmpb_pkg::FLAG0_BIT] = ~host_full_q;
			pc_pins[mmpb_pkg::LOAD_BIT]  = mcu_full_q;
		end else begin
			pc_pins[mmpb_pkg::FLAG0_BIT] = host_full_q;
			pc_pins[mmpb_pkg::LOAD_BIT]  = ~mcu_full_q;
		end
	end

	always_comb begin
		host_byte_d = host_byte_q;
		mcu_byte_d  = mcu_byte_q;
		host_full_d = host_full_q;
		mcu_full_d  = mcu_full_q;
		irq_d       = irq_q;
		pa_in_d     = pa_in_q;
		pa_out_d    = pa_out_q;
		pa_dir_d    = pa_dir_q;
		pb_out_d    = pb_out_q;
		pb_dir_d    = pb_dir_q;
		pc_out_d    = pc_out_q;
		pc_dir_d    = pc_dir_q;
		scr_lo_d    = scr_lo_q;
		scr_hi_d    = scr_hi_q;
		rd          = '0;
		unique case (action)
			mmpb_pkg::ACT_HOST_WR: begin
				host_byte_d = data;
				host_full_d = 1'b1;
				irq_d       = 1'b1;
				if (variant) begin
					mcu_full_d = 1'b0;
				end
			end
			mmpb_pkg::ACT_HOST_RD: begin
				mcu_full_d = 1'b0;
				rd         = mcu_byte_q;
			end
			mmpb_pkg::ACT_HOST_STAT: begin
				rd[mmpb_pkg::LOAD_BIT] = ~host_full_q;
				rd[mmpb_pkg::SEND_BIT] = ~mcu_full_q;
			end
			mmpb_pkg::ACT_PA_WR: begin
				pa_out_d = data;
				if (variant) begin
					mcu_byte_d = data;
					mcu_full_d = 1'b1;
				end
			end
			mmpb_pkg::ACT_PA_DDR: pa_dir_d = data;
			mmpb_pkg::ACT_PA_RD:  rd = (pa_out_q & pa_dir_q) | (pa_in_q & ~pa_dir_q);
			mmpb_pkg::ACT_PB_WR: begin
				if (pb_fall[mmpb_pkg::LOAD_BIT]) begin
					pa_in_d     = host_byte_q;
					irq_d       = 1'b0;
					host_full_d = 1'b0;
				end
				if (pb_rise[mmpb_pkg::SEND_BIT]) begin
					mcu_byte_d = pa_out_q;
					mcu_full_d = 1'b1;
				end
				if (!variant && pb_fall[mmpb_pkg::SCRLO_BIT]) begin
					scr_lo_d = pa_out_q;
				end
				if (!variant && pb_fall[mmpb_pkg::SCRHI_BIT]) begin
					scr_hi_d = pa_out_q;
				end
				pb_out_d = data;
			end
			mmpb_pkg::ACT_PB_DDR: pb_dir_d = data;
			mmpb_pkg::ACT_PB_RD:  rd = pb_out_q & pb_dir_q;
			mmpb_pkg::ACT_PC_WR:  pc_out_d = data;
			mmpb_pkg::ACT_PC_DDR: pc_dir_d = data;
			mmpb_pkg::ACT_PC_RD:  rd = (pc_out_q & pc_dir_q) | (pc_pins & ~pc_dir_q);
			default: ;
		endcase
	end

	// The result reflects the state as it stands after this request.
	assign result.read_data   = rd;
	assign result.mcu_irq     = irq_d;
	assign result.scroll_low  = scr_lo_d;
	assign result.scroll_high = scr_hi_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			host_byte_q <= '0;
			mcu_byte_q  <= '0;
			host_full_q <= 1'b0;
			mcu_full_q  <= 1'b0;
			irq_q       <= 1'b0;
			pa_in_q     <= '0;
			pa_out_q    <= '0;
			pa_dir_q    <= '0;
			pb_out_q    <= '0;
			pb_dir_q    <= '0;
			pc_out_q    <= '0;
			pc_dir_q    <= '0;
			scr_lo_q    <= '0;
			scr_hi_q    <= '0;
		end else if (accept) begin
			host_byte_q <= host_byte_d;
			mcu_byte_q  <= mcu_byte_d;
			host_full_q <= host_full_d;
			mcu_full_q  <= mcu_full_d;
			irq_q       <= irq_d;
			pa_in_q     <= pa_in_d;
			pa_out_q    <= pa_out_d;
			pa_dir_q    <= pa_dir_d;
			pb_out_q    <= pb_out_d;
			pb_dir_q    <= pb_dir_d;
			pc_out_q    <= pc_out_d;
			pc_dir_q    <= pc_dir_d;
			scr_lo_q    <= scr_lo_d;
			scr_hi_q    <= scr_hi_d;
		end
	end

	a_host_wr_irq: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == mmpb_pkg::ACT_HOST_WR |=> irq_q && host_full_q)
		else $error("host write did not raise the interrupt and the full flag");

	a_host_rd_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && action == mmpb_pkg::ACT_HOST_RD |=> !mcu_full_q)
		else $error("host read did not clear the MCU full flag");

	a_irq_tracks_full: assert property (@(posedge clk) disable iff (!arst_n)
		irq_q == host_full_q)
		else $error("interrupt line and host full flag disagree");

endmodule

[hw/rtl/mcu_mailbox_port_bridge.sv]
// ----------------------------------------------------------------------------
// mcu_mailbox_port_bridge
// Byte mailbox between a host CPU and a microcontroller with three ports.
// ----------------------------------------------------------------------------
// Result path: the result of an accepted request is registered in the output
// register, or in the skid register while the output is stalled.
// Throughput: one request per cycle; while the output is stalled one more
// request parks in the skid register, then the request side stalls until the
// output drains.
// Reset: arst_n clears all mailbox, port and scroll latches and the variant.
module mcu_mailbox_port_bridge (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel.
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [mmpb_pkg::ACTION_W-1:0] action,
	input  logic [mmpb_pkg::BYTE_W-1:0]   data,
	// Result channel.
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [mmpb_pkg::BYTE_W-1:0]   read_data,
	output logic                          mcu_irq,
	output logic [mmpb_pkg::BYTE_W-1:0]   scroll_low,
	output logic [mmpb_pkg::BYTE_W-1:0]   scroll_high,
	// Configuration port.
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [2:0]                    paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready
);

	logic              variant_q;
	logic              accept;
	logic              take;
	logic              out_free;
	mmpb_pkg::result_t result;
	mmpb_pkg::result_t out_q, skid_q;
	logic              out_valid_q, skid_valid_q;

	// The configuration register is a single bit, decoded from address bit 2
	// alone: byte addresses 0 to 3 all reach it and 4 to 7 are ignored.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == mmpb_pkg::REG_VARIANT) ? {31'd0, variant_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			variant_q <= 1'b0;
		end else if (psel && penable && pwrite && pready &&
			paddr[2] == mmpb_pkg::REG_VARIANT) begin
			variant_q <= pwdata[0];
		end
	end

	// The request side stalls only when the skid register holds a result, so
	// the stall is a registered signal and never follows out_stall directly.
	assign in_stall = skid_valid_q;
	assign accept   = in_valid && !in_stall;
	assign take     = out_valid_q && !out_stall;
	assign out_free = !out_valid_q || take;

	// All state updates and the result of the accepted request are worked
	// out in one short pass of logic inside the core.
	mmpb_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.action  (action),
		.data    (data),
		.variant (variant_q),
		.result  (result)
	);

	// Output buffer: the output register is refilled from the skid register
	// first, then from a freshly accepted request. When the output register
	// is held by a stall, a new result parks in the skid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_free) begin
				out_valid_q  <= skid_valid_q || accept;
				skid_valid_q <= 1'b0;
			end else if (accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (accept) begin
				out_q <= result;
			end
		end else if (accept) begin
			skid_q <= result;
		end
	end

	assign out_valid   = out_valid_q;
	assign read_data   = out_q.read_data;
	assign mcu_irq     = out_q.mcu_irq;
	assign scroll_low  = out_q.scroll_low;
	assign scroll_high = out_q.scroll_high;

	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output is empty");

	a_park_in_skid: assert property (@(posedge clk) disable iff (!arst_n)
		accept && out_valid_q && out_stall |=> skid_valid_q)
		else $error("result of a request accepted under stall was dropped");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q && !out_stall |=> !skid_valid_q && out_valid_q)
		else $error("skid register did not drain into the output register");

endmodule
